// File: sv/text_marquee_scroller_defines.svh
// Assertion macros for the text marquee scroller.
`ifndef TEXT_MARQUEE_SCROLLER_DEFINES_SVH
`define TEXT_MARQUEE_SCROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define TMS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("text_marquee_scroller: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TMS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("text_marquee_scroller: check failed");

`else

`define TMS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TMS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/tms_pkg.sv
// Shared constants and codes for the text marquee scroller.
`timescale 1ns / 1ps

package tms_pkg;

	localparam int WINDOW_CHARS  = 8;
	localparam int TEXT_CAPACITY = 128;
	localparam int GAP_CHARS     = 8;
	localparam int TITLE_ROOM    = TEXT_CAPACITY - GAP_CHARS;

	localparam int ADDR_W    = $clog2(TEXT_CAPACITY);
	localparam int LEN_W     = $clog2(TEXT_CAPACITY + 1);
	localparam int WIN_CNT_W = $clog2(WINDOW_CHARS + 1);
	localparam int PUT_CNT_W = $clog2(GAP_CHARS + 2);

	localparam logic [15:0] INTERVAL_RESET = 16'd300;
	localparam logic [7:0]  SPACE_CHAR     = 8'h20;

	localparam logic [1:0] CMD_LOAD       = 2'd0;
	localparam logic [1:0] CMD_TICK       = 2'd1;
	localparam logic [1:0] CMD_DISCONNECT = 2'd2;
	localparam logic [1:0] CMD_NOTICE     = 2'd3;

endpackage

// File: sv/tms_ifs.sv
// Valid/ready channel interfaces for the marquee input and output.
`timescale 1ns / 1ps

interface tms_in_if import tms_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  text_char;
	logic        text_last;
	logic [31:0] now_ms;
	logic        transient_active;
	logic        is_aux;

	modport source (output valid, command, text_char, text_last, now_ms,
		transient_active, is_aux, input ready);
	modport sink (input valid, command, text_char, text_last, now_ms,
		transient_active, is_aux, output ready);
endinterface

interface tms_out_if import tms_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] shown_char;
	logic       window_last;

	modport source (output valid, shown_char, window_last, input ready);
	modport sink (input valid, shown_char, window_last, output ready);
endinterface

// File: sv/text_marquee_scroller.sv
// Scrolling text marquee: title store, scroll timing and window output.
//
//  channel  | dir | payload                                            | per transaction
//  ---------+-----+----------------------------------------------------+------------------
//  in_ch    | in  | command, text_char, text_last, now_ms, transient,  | one command
//           |     | is_aux                                             |
//  out_ch   | out | shown_char, window_last                            | one window char
//  cfg      | in  | cfg_we, cfg_wdata (scroll interval, ms)            | one write
//
//  A tick that shows a window reads the text memory once per character,
//  through one read port with a registered read. A plain load char is
//  accepted, then its old byte is read, then compared and written; the last
//  char is accepted, then each of up to 9 bytes is read and compared/written,
//  and then the load closes. Other commands complete when accepted.
//  Output stalls hold the read pipeline.
//  arst_n clears all control state; the text memory is not cleared.
`timescale 1ns / 1ps

`include "text_marquee_scroller_defines.svh"

module text_marquee_scroller import tms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	tms_in_if.sink      in_ch,
	tms_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PUT_RD = 3'd1;
	localparam logic [2:0] S_PUT_WR = 3'd2;
	localparam logic [2:0] S_FINISH = 3'd3;
	localparam logic [2:0] S_EMIT   = 3'd4;

	logic [2:0]  state_q;

	// marquee state
	logic [LEN_W-1:0]  text_length_q;
	logic [ADDR_W-1:0] load_index_q;
	logic              load_differs_q;
	logic [ADDR_W-1:0] scroll_pos_q;
	logic [31:0]       last_scroll_q;
	logic              playing_q;
	logic              static_shown_q;
	logic [15:0]       interval_q;

	// byte writer for loads
	logic [ADDR_W-1:0]    put_addr_q;
	logic [7:0]           put_char_q;
	logic [PUT_CNT_W-1:0] put_left_q;
	logic                 put_last_q;

	// window reader
	logic [ADDR_W-1:0]    emit_idx_q;
	logic [WIN_CNT_W-1:0] emit_i_q;
	logic                 wrap_q;
	logic                 rd_valid_s1;
	logic                 last_s1;
	logic [7:0]           rd_data_s1;

	// output register
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_last_q;

	logic [7:0] text_mem [TEXT_CAPACITY];

	logic              in_fire;
	logic              can_move;
	logic              s1_free;
	logic              emit_issue;
	logic              rd_en;
	logic              mem_we;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] emit_addr;
	logic [LEN_W-1:0]  emit_inc;
	logic [LEN_W-1:0]  scroll_inc;
	logic [31:0]       elapsed;
	logic              keep_char;
	logic [LEN_W-1:0]  total_len;
	logic              put_differs;

	assign in_ch.ready        = (state_q == S_IDLE);
	assign in_fire            = in_ch.valid & in_ch.ready;
	assign out_ch.valid       = out_valid_q;
	assign out_ch.shown_char  = out_char_q;
	assign out_ch.window_last = out_last_q;

	always_comb begin
		can_move   = !out_valid_q || out_ch.ready;
		s1_free    = !rd_valid_s1 || can_move;
		emit_issue = (state_q == S_EMIT) && (emit_i_q != WIN_CNT_W'(WINDOW_CHARS)) && s1_free;
		// paused view: positions past the text show position 0
		if (wrap_q) begin
			emit_addr = emit_idx_q;
		end else if (LEN_W'(emit_i_q) < text_length_q) begin
			emit_addr = ADDR_W'(emit_i_q);
		end else begin
			emit_addr = '0;
		end
		rd_en       = emit_issue || (state_q == S_PUT_RD);
		rd_addr     = (state_q == S_PUT_RD) ? put_addr_q : emit_addr;
		mem_we      = (state_q == S_PUT_WR);
		emit_inc    = LEN_W'(emit_idx_q) + LEN_W'(1);
		scroll_inc  = LEN_W'(scroll_pos_q) + LEN_W'(1);
		elapsed     = in_ch.now_ms - last_scroll_q;
		keep_char   = LEN_W'(load_index_q) < LEN_W'(TITLE_ROOM);
		total_len   = LEN_W'(load_index_q) + LEN_W'(GAP_CHARS);
		put_differs = (LEN_W'(put_addr_q) >= text_length_q) || (rd_data_s1 != put_char_q);
	end

	// text memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			text_mem[put_addr_q] <= put_char_q;
		end
		if (rd_en) begin
			rd_data_s1 <= text_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
		end else if (cfg_we) begin
			interval_q <= cfg_wdata;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (emit_issue) begin
			last_s1 <= (emit_i_q == WIN_CNT_W'(WINDOW_CHARS - 1));
		end
		if (rd_valid_s1 && can_move) begin
			out_char_q <= rd_data_s1;
			out_last_q <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_issue) begin
				rd_valid_s1 <= 1'b1;
			end else if (can_move) begin
				rd_valid_s1 <= 1'b0;
			end
			if (rd_valid_s1 && can_move) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			text_length_q  <= '0;
			load_index_q   <= '0;
			load_differs_q <= 1'b0;
			scroll_pos_q   <= '0;
			last_scroll_q  <= '0;
			playing_q      <= 1'b0;
			static_shown_q <= 1'b0;
			put_addr_q     <= '0;
			put_char_q     <= '0;
			put_left_q     <= '0;
			put_last_q     <= 1'b0;
			emit_idx_q     <= '0;
			emit_i_q       <= '0;
			wrap_q         <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						case (in_ch.command)
							CMD_LOAD: begin
								put_last_q <= in_ch.text_last;
								if (keep_char) begin
									// kept char first, then the gap if last
									put_addr_q   <= load_index_q;
									put_char_q   <= in_ch.text_char;
									put_left_q   <= in_ch.text_last ?
										PUT_CNT_W'(GAP_CHARS + 1) : PUT_CNT_W'(1);
									load_index_q <= load_index_q + ADDR_W'(1);
									state_q      <= S_PUT_RD;
								end else if (in_ch.text_last) begin
									// title full: gap only
									put_addr_q <= load_index_q;
									put_char_q <= SPACE_CHAR;
									put_left_q <= PUT_CNT_W'(GAP_CHARS);
									state_q    <= S_PUT_RD;
								end
							end
							CMD_TICK: begin
								if (!in_ch.transient_active && text_length_q != '0) begin
									if (!playing_q) begin
										if (!static_shown_q) begin
											static_shown_q <= 1'b1;
											wrap_q         <= 1'b0;
											emit_i_q       <= '0;
											emit_idx_q     <= '0;
											state_q        <= S_EMIT;
										end
									end else if (elapsed >= 32'(interval_q)) begin
										last_scroll_q <= in_ch.now_ms;
										wrap_q        <= 1'b1;
										emit_i_q      <= '0;
										emit_idx_q    <= scroll_pos_q;
										scroll_pos_q  <= (scroll_inc == text_length_q) ?
											'0 : scroll_inc[ADDR_W-1:0];
										state_q       <= S_EMIT;
									end
								end
							end
							CMD_DISCONNECT: begin
								playing_q <= 1'b0;
							end
							CMD_NOTICE: begin
								if (in_ch.is_aux) begin
									static_shown_q <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_PUT_RD: begin
					state_q <= S_PUT_WR;
				end
				S_PUT_WR: begin
					if (put_differs) begin
						load_differs_q <= 1'b1;
					end
					put_addr_q <= put_addr_q + ADDR_W'(1);
					put_char_q <= SPACE_CHAR;
					put_left_q <= put_left_q - PUT_CNT_W'(1);
					if (put_left_q == PUT_CNT_W'(1)) begin
						state_q <= put_last_q ? S_FINISH : S_IDLE;
					end else begin
						state_q <= S_PUT_RD;
					end
				end
				S_FINISH: begin
					// only a changed text restarts the scroll
					if (load_differs_q || total_len != text_length_q) begin
						text_length_q <= total_len;
						scroll_pos_q  <= '0;
						last_scroll_q <= '0;
					end
					if (!playing_q) begin
						static_shown_q <= 1'b0;
					end
					playing_q      <= 1'b1;
					load_index_q   <= '0;
					load_differs_q <= 1'b0;
					state_q        <= S_IDLE;
				end
				S_EMIT: begin
					if (emit_issue && wrap_q) begin
						emit_idx_q <= (emit_inc == text_length_q) ?
							'0 : emit_inc[ADDR_W-1:0];
					end
					if (emit_issue) begin
						emit_i_q <= emit_i_q + WIN_CNT_W'(1);
					end
					if (rd_valid_s1 && can_move && last_s1) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`TMS_ASSERT_IMP(a_scroll_in_text, clk, arst_n, text_length_q != '0, LEN_W'(scroll_pos_q) < text_length_q)
	`TMS_ASSERT_IMP(a_len_has_gap, clk, arst_n, text_length_q != '0, text_length_q >= LEN_W'(GAP_CHARS))
	`TMS_ASSERT_IMP(a_read_only_in_emit, clk, arst_n, rd_valid_s1, state_q == S_EMIT)
	`TMS_ASSERT_IMP(a_emit_count, clk, arst_n, state_q == S_EMIT, emit_i_q <= WIN_CNT_W'(WINDOW_CHARS))
	`TMS_ASSERT_NXT(a_finish_plays, clk, arst_n, state_q == S_FINISH, playing_q && load_index_q == '0)

endmodule

// File: tb/marquee_window_checker.sv
`timescale 1ns / 1ps
// Checker for the marquee scroller: predicts each window from the commands seen, compares results.
module marquee_window_checker import tms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	tms_in_if           in_mon,
	tms_out_if          out_mon,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output int          errors,
	output int          outstanding
);

	typedef struct packed {
		logic [7:0] glyph;
		logic       tail;
	} window_char_t;

	window_char_t window_q[$];

	logic [7:0]  title_mem [TEXT_CAPACITY];
	logic [7:0]  text_len;
	logic [7:0]  fill_idx;
	logic        fill_changed;
	logic [6:0]  scroll_pos;
	logic [31:0] last_step_ms;
	logic        running;
	logic        still_done;
	logic [15:0] step_ms;

	task automatic write_glyph(input int pos, input logic [7:0] c);
		if (pos < TEXT_CAPACITY) begin
			if (pos >= text_len || title_mem[pos] != c)
				fill_changed = 1'b1;
			title_mem[pos] = c;
		end
	endtask

	task automatic absorb_char(input logic [7:0] c, input logic fin);
		logic [7:0] total;
		if (fill_idx < TITLE_ROOM) begin
			write_glyph(int'(fill_idx), c);
			fill_idx = fill_idx + 8'd1;
		end
		if (fin) begin
			for (int g = 0; g < GAP_CHARS; g++)
				write_glyph(int'(fill_idx) + g, SPACE_CHAR);
			total = fill_idx + 8'(GAP_CHARS);
			if (total != text_len)
				fill_changed = 1'b1;
			if (fill_changed) begin
				text_len     = total;
				scroll_pos   = '0;
				last_step_ms = '0;
			end
			if (!running)
				still_done = 1'b0;
			running      = 1'b1;
			fill_idx     = '0;
			fill_changed = 1'b0;
		end
	endtask

	task automatic emit_window(input logic [6:0] start, input logic wrap);
		int idx;
		for (int i = 0; i < WINDOW_CHARS; i++) begin
			if (wrap)
				idx = (int'(start) + i) % int'(text_len);
			else
				idx = (i < text_len) ? i : 0;
			if (idx >= TEXT_CAPACITY)
				idx = 0;
			window_q.push_back('{glyph: title_mem[idx], tail: (i == WINDOW_CHARS - 1)});
		end
	endtask

	task automatic take_tick(input logic [31:0] now, input logic busy);
		logic [31:0] elapsed;
		if (busy || text_len == 0)
			return;
		if (!running) begin
			if (still_done)
				return;
			still_done = 1'b1;
			emit_window('0, 1'b0);
			return;
		end
		elapsed = now - last_step_ms;
		if (elapsed < {16'd0, step_ms})
			return;
		last_step_ms = now;
		emit_window(scroll_pos, 1'b1);
		scroll_pos = 7'((int'(scroll_pos) + 1) % int'(text_len));
	endtask

	always @(posedge clk or negedge arst_n) begin
		window_char_t want;
		if (!arst_n) begin
			foreach (title_mem[i])
				title_mem[i] = '0;
			text_len     = '0;
			fill_idx     = '0;
			fill_changed = 1'b0;
			scroll_pos   = '0;
			last_step_ms = '0;
			running      = 1'b0;
			still_done   = 1'b0;
			step_ms      = INTERVAL_RESET;
			window_q.delete();
			errors       = 0;
			outstanding  = 0;
		end else begin
			if (cfg_we)
				step_ms = cfg_wdata;
			if (in_mon.valid && in_mon.ready) begin
				case (in_mon.command)
					CMD_LOAD:       absorb_char(in_mon.text_char, in_mon.text_last);
					CMD_TICK:       take_tick(in_mon.now_ms, in_mon.transient_active);
					CMD_DISCONNECT: running = 1'b0;
					CMD_NOTICE:     if (in_mon.is_aux) still_done = 1'b0;
					default:        ;
				endcase
			end
			if (out_mon.valid && out_mon.ready) begin
				if (window_q.size() == 0) begin
					errors++;
					$display("%0t: window char %h/%b arrived with nothing expected",
						$time, out_mon.shown_char, out_mon.window_last);
				end else begin
					want = window_q.pop_front();
					if (out_mon.shown_char !== want.glyph
							|| out_mon.window_last !== want.tail) begin
						errors++;
						$display("%0t: window char mismatch: expected %h/%b, got %h/%b",
							$time, want.glyph, want.tail,
							out_mon.shown_char, out_mon.window_last);
					end
				end
			end
			outstanding = window_q.size();
		end
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top level: stimulus, handshake idling and final verdict for the marquee scroller.
module testbench;
	import tms_pkg::*;

	localparam int CLK_HALF      = 10;    // 20 ns period
	localparam int RESET_CYCLES  = 12;
	localparam int STALL_LIMIT   = 2000;  // cycles with no transaction on either channel
	localparam int SETTLE_CYCLES = 32;    // time for the last load char to close
	localparam int PHASE_ITEMS   = 20;
	localparam int HOLD_CYCLES   = 250;   // long receiver hold-off to back the block up
	localparam int HOLD_AFTER    = 60;    // input transactions before the hold-off may start
	localparam int PHASES        = 5;
	localparam logic [15:0] PHASE_MS [PHASES - 1] = '{16'd0, 16'd1, 16'hFFFF, INTERVAL_RESET};

	typedef enum {TITLE_FRESH, TITLE_SAME, TITLE_TWEAK, TITLE_RESIZE} title_mode_e;
	typedef enum {RX_OPEN, RX_ALTERNATE, RX_SPARSE, RX_DENSE} rx_mode_e;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	tms_in_if  in_ch();
	tms_out_if out_ch();

	int errors;
	int outstanding;
	int sent_count;
	int burst_left;
	int idle_cycles;

	// Millisecond clock as the stimulus sees it; ticks mostly move it forwards.
	logic [31:0] clock_ms;
	logic [15:0] cur_interval;
	logic [7:0]  last_title[$];

	text_marquee_scroller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	marquee_window_checker window_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_mon      (in_ch),
		.out_mon     (out_ch),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Watchdog: a correct run never goes this long without a transaction.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver: segments of differing stall patterns, plus one long hold-off once the
	// block has results queued, so that it fills and pushes back on its input.
	initial begin
		rx_mode_e mode;
		int       seg_left;
		int       hold_left;
		bit       held_once;
		out_ch.ready = 1'b0;
		mode      = RX_OPEN;
		seg_left  = 0;
		hold_left = 0;
		held_once = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held_once && sent_count >= HOLD_AFTER && out_ch.valid) begin
				held_once = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode     = rx_mode_e'($urandom_range(0, 3));
					seg_left = $urandom_range(10, 60);
				end
				seg_left--;
				case (mode)
					RX_OPEN:      out_ch.ready <= 1'b1;
					RX_ALTERNATE: out_ch.ready <= seg_left[0];
					RX_SPARSE:    out_ch.ready <= ($urandom_range(0, 3) == 0);
					default:      out_ch.ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// One input transaction. The sender runs in bursts; between bursts valid may drop for
	// a random gap. Valid is never lowered and raised in the same step.
	task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] ch, input logic fin,
			input logic [31:0] now, input logic busy, input logic aux);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_ch.valid            <= 1'b1;
		in_ch.command          <= cmd;
		in_ch.text_char        <= ch;
		in_ch.text_last        <= fin;
		in_ch.now_ms           <= now;
		in_ch.transient_active <= busy;
		in_ch.is_aux           <= aux;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent_count++;
	endtask

	// Tick at a given time; the fields a tick ignores carry noise.
	task automatic tick_at(input logic [31:0] now, input logic busy);
		clock_ms = now;
		send_cmd(CMD_TICK, 8'($urandom), 1'($urandom), now, busy, 1'($urandom));
	endtask

	task automatic tick(input logic [31:0] advance, input logic busy);
		tick_at(clock_ms + advance, busy);
	endtask

	// Steps around the current interval, with the odd large jump across the wrap.
	function automatic logic [31:0] pick_advance();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 2)
			return 32'd0;
		else if (roll < 4)
			return {16'd0, cur_interval} - 32'd1;
		else if (roll < 6)
			return {16'd0, cur_interval};
		else if (roll < 9)
			return {16'd0, cur_interval} + 32'($urandom_range(1, 500));
		return 32'($urandom);
	endfunction

	// Feed a title one char per transaction; ticks may fall in the middle of it.
	task automatic send_title(input logic [7:0] chars[$], input bit with_ticks);
		foreach (chars[i]) begin
			if (with_ticks && $urandom_range(0, 2) == 0)
				tick(pick_advance(), 1'b0);
			send_cmd(CMD_LOAD, chars[i], (i == chars.size() - 1), 32'($urandom),
				1'($urandom), 1'($urandom));
		end
	endtask

	// Reload the same text, a one-char change, a length change, or a new title.
	task automatic load_title(input int len, input title_mode_e mode, input bit with_ticks);
		logic [7:0] chars[$];
		int         k;
		if (last_title.size() == 0)
			mode = TITLE_FRESH;
		case (mode)
			TITLE_SAME: chars = last_title;
			TITLE_TWEAK: begin
				chars    = last_title;
				k        = $urandom_range(0, chars.size() - 1);
				chars[k] = chars[k] ^ 8'($urandom_range(1, 255));
			end
			TITLE_RESIZE: begin
				chars = last_title;
				if (chars.size() > 1 && $urandom_range(0, 1))
					void'(chars.pop_back());
				else
					chars.push_back(8'($urandom));
			end
			default: repeat (len) chars.push_back(8'($urandom));
		endcase
		send_title(chars, with_ticks);
		last_title = chars;
	endtask

	// Drain: wait for every expected result, then give a closing load time to finish.
	task automatic settle();
		in_ch.valid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_interval(input logic [15:0] ms);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= ms;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_interval = ms;
	endtask

	task automatic run_phase(input int items);
		int stop;
		int roll;
		stop = sent_count + items;
		while (sent_count < stop) begin
			roll = $urandom_range(0, 99);
			if (roll < 30)
				load_title($urandom_range(1, 10), title_mode_e'($urandom_range(0, 3)),
					($urandom_range(0, 4) == 0));
			else if (roll < 80)
				tick(pick_advance(), ($urandom_range(0, 9) == 0));
			else if (roll < 88)
				send_cmd(CMD_DISCONNECT, 8'($urandom), 1'($urandom), 32'($urandom),
					1'($urandom), 1'($urandom));
			else if (roll < 96)
				send_cmd(CMD_NOTICE, 8'($urandom), 1'($urandom), 32'($urandom),
					1'($urandom), 1'($urandom));
			else
				send_cmd(2'($urandom), 8'($urandom), 1'($urandom), 32'($urandom),
					1'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		in_ch.valid            = 1'b0;
		in_ch.command          = CMD_LOAD;
		in_ch.text_char        = '0;
		in_ch.text_last        = 1'b0;
		in_ch.now_ms           = '0;
		in_ch.transient_active = 1'b0;
		in_ch.is_aux           = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		arst_n       = 1'b0;
		clock_ms     = '0;
		cur_interval = INTERVAL_RESET;
		sent_count   = 0;
		burst_left   = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, at the reset interval.
		tick_at(32'd0, 1'b0);                                  // empty store: no window
		send_cmd(CMD_DISCONNECT, '0, 1'b0, '0, 1'b0, 1'b0);
		send_cmd(CMD_NOTICE, '0, 1'b0, '0, 1'b0, 1'b1);
		send_cmd(CMD_NOTICE, '0, 1'b0, '0, 1'b0, 1'b0);
		last_title = '{8'h00, 8'hFF};                          // char extremes
		send_title(last_title, 1'b0);
		tick_at(32'd0, 1'b0);                                  // too soon
		tick_at(32'd300, 1'b0);                                // exactly one interval
		tick_at(32'd599, 1'b0);
		tick_at(32'd600, 1'b0);
		tick_at(32'hFFFF_FFFF, 1'b1);                          // another message owns it
		send_cmd(CMD_DISCONNECT, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1);
		tick(32'd1, 1'b0);                                     // paused: static view once
		tick(32'd1, 1'b0);
		send_cmd(CMD_NOTICE, '0, 1'b0, '0, 1'b0, 1'b0);        // not AUX: nothing
		tick(32'd1, 1'b0);
		send_cmd(CMD_NOTICE, '0, 1'b0, '0, 1'b0, 1'b1);        // AUX re-arms static view
		tick(32'd1, 1'b0);
		load_title(0, TITLE_SAME, 1'b0);                       // same text: position kept
		tick_at(32'hFFFF_FFF0, 1'b0);
		tick_at(32'h0000_0010, 1'b0);                          // across the wrap, too soon
		tick_at(32'h0000_0200, 1'b0);

		// Random part, one phase per interval setting; the last one random.
		for (int p = 0; p < PHASES; p++) begin
			if (p < PHASES - 1)
				set_interval(PHASE_MS[p]);
			else
				set_interval(16'($urandom_range(2, 2000)));
			run_phase(PHASE_ITEMS);
		end

		settle();
		if (errors == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
